>>> sv/slr_pkg.sv
// shared types and command codes of the sparse layer forward block
package slr_pkg;

   localparam logic [2:0] CMD_INPUT   = 3'd0;
   localparam logic [2:0] CMD_BIAS    = 3'd1;
   localparam logic [2:0] CMD_CONN    = 3'd2;
   localparam logic [2:0] CMD_RANGE   = 3'd3;
   localparam logic [2:0] CMD_COMPUTE = 3'd4;

   localparam logic signed [15:0] Q_MAX = 16'sh7FFF;
   localparam logic signed [15:0] Q_MIN = 16'sh8000;

   typedef struct packed {
      logic [2:0]         command;
      logic [13:0]        index;
      logic [9:0]         source;
      logic signed [15:0] value;
      logic [14:0]        range_begin;
      logic [14:0]        range_end;
   } req_payload_type;

   typedef struct packed {
      logic [9:0]         neuron;
      logic signed [15:0] pre_activation;
      logic signed [15:0] activation;
   } rsp_payload_type;

endpackage

>>> sv/slr_stream_if.sv
// valid/ready stream channel carrying one payload per beat
interface slr_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

>>> sv/slr_ram.sv
// generic single write port, single read port ram with registered read
module slr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/sparse_layer_forward_leaky_relu.sv
// sparse layer forward pass: store writes and per-neuron multiply-accumulate with leaky relu
// store writes leave the sequencer idle, so the block stays ready after each beat
// compute of a neuron reads its bias and range, walks its connections and registers its
// result once an earlier result has left the response slot; ready returns after that;
// one connection a cycle through the connection ram, input ram, multiplier
// reset clears the sequencer, the pipeline valids and the response valid; the rams are not cleared
module sparse_layer_forward_leaky_relu #(
   parameter int INPUT_COUNT      = 1024,
   parameter int NEURON_COUNT     = 1024,
   parameter int CONNECTION_COUNT = 16384
) (
   input  logic         clock,
   input  logic         reset,
   slr_stream_if.sink   req_if,
   slr_stream_if.source rsp_if
);

   import slr_pkg::*;

   localparam int IAW   = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
   localparam int NAW   = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
   localparam int CAW   = (CONNECTION_COUNT > 1) ? $clog2(CONNECTION_COUNT) : 1;
   localparam int CNT_W = $clog2(CONNECTION_COUNT + 1);
   localparam int PTR_W = (CNT_W > 15) ? CNT_W : 15;
   localparam int ACC_W = 34 + CNT_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RANGE  = 2'd1;
   localparam logic [1:0] ST_WALK   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   localparam logic signed [ACC_W-13:0] SAT_MAX = (ACC_W-12)'(Q_MAX);
   localparam logic signed [ACC_W-13:0] SAT_MIN = (ACC_W-12)'(Q_MIN);

   logic [1:0] state_ff, state_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [PTR_W-1:0] end_ff, end_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [9:0] neuron_ff, neuron_in;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic signed [15:0] s2_weight_ff;
   logic s2_ok_ff;
   logic signed [31:0] prod_ff;

   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;

   logic req_fire;
   logic [31:0] idx_wide;
   logic [31:0] src_wide;
   logic input_wr_en, bias_wr_en, conn_wr_en, range_wr_en;
   logic neuron_ok;
   logic issue;
   logic slot_free;
   logic rsp_load;

   logic [15:0] input_rd_data;
   logic [15:0] bias_rd_data;
   logic [25:0] conn_rd_data;
   logic [29:0] range_rd_data;
   logic [IAW-1:0] input_rd_addr;

   logic [PTR_W-1:0] range_end_wide;
   logic [PTR_W-1:0] range_end_clamped;
   logic signed [15:0] x_sel;
   logic signed [ACC_W-1:0] rnd;
   logic signed [ACC_W-13:0] rnd_sh;
   logic signed [15:0] pre_sat;
   logic signed [15:0] act;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign idx_wide     = 32'(req_if.payload.index);

   assign input_wr_en = req_fire && (req_if.payload.command == CMD_INPUT)
                        && (idx_wide < 32'(INPUT_COUNT));
   assign bias_wr_en  = req_fire && (req_if.payload.command == CMD_BIAS)
                        && (idx_wide < 32'(NEURON_COUNT));
   assign conn_wr_en  = req_fire && (req_if.payload.command == CMD_CONN)
                        && (idx_wide < 32'(CONNECTION_COUNT));
   assign range_wr_en = req_fire && (req_if.payload.command == CMD_RANGE)
                        && (idx_wide < 32'(NEURON_COUNT));
   assign neuron_ok   = idx_wide < 32'(NEURON_COUNT);

   // connection walk: one read of the connection ram per cycle
   assign issue = (state_ff == ST_WALK) && (ptr_ff < end_ff);

   // source decoded from the connection beat just read
   assign src_wide      = 32'(conn_rd_data[25:16]);
   assign input_rd_addr = src_wide[IAW-1:0];

   slr_ram #(.WIDTH(16), .DEPTH(INPUT_COUNT)) u_input_ram (
      .clock   (clock),
      .wr_en   (input_wr_en),
      .wr_addr (idx_wide[IAW-1:0]),
      .wr_data (req_if.payload.value),
      .rd_addr (input_rd_addr),
      .rd_data (input_rd_data)
   );

   slr_ram #(.WIDTH(16), .DEPTH(NEURON_COUNT)) u_bias_ram (
      .clock   (clock),
      .wr_en   (bias_wr_en),
      .wr_addr (idx_wide[NAW-1:0]),
      .wr_data (req_if.payload.value),
      .rd_addr (idx_wide[NAW-1:0]),
      .rd_data (bias_rd_data)
   );

   slr_ram #(.WIDTH(26), .DEPTH(CONNECTION_COUNT)) u_conn_ram (
      .clock   (clock),
      .wr_en   (conn_wr_en),
      .wr_addr (idx_wide[CAW-1:0]),
      .wr_data ({req_if.payload.source, req_if.payload.value}),
      .rd_addr (ptr_ff[CAW-1:0]),
      .rd_data (conn_rd_data)
   );

   slr_ram #(.WIDTH(30), .DEPTH(NEURON_COUNT)) u_range_ram (
      .clock   (clock),
      .wr_en   (range_wr_en),
      .wr_addr (idx_wide[NAW-1:0]),
      .wr_data ({req_if.payload.range_end, req_if.payload.range_begin}),
      .rd_addr (idx_wide[NAW-1:0]),
      .rd_data (range_rd_data)
   );

   // end of range clamped to the connection store
   assign range_end_wide    = PTR_W'(range_rd_data[29:15]);
   assign range_end_clamped = (range_end_wide > PTR_W'(CONNECTION_COUNT))
                              ? PTR_W'(CONNECTION_COUNT) : range_end_wide;

   // sources beyond the input store contribute zero
   assign x_sel = s2_ok_ff ? $signed(input_rd_data) : 16'sd0;

   // round half up to q4.12, then saturate
   assign rnd    = acc_ff + ACC_W'(2048);
   assign rnd_sh = rnd[ACC_W-1:12];

   always_comb begin
      priority if (rnd_sh > SAT_MAX) begin
         pre_sat = Q_MAX;
      end else if (rnd_sh < SAT_MIN) begin
         pre_sat = Q_MIN;
      end else begin
         pre_sat = rnd_sh[15:0];
      end
   end

   assign act = (pre_sat > 16'sd0) ? pre_sat : {pre_sat[15], pre_sat[15:1]};

   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign rsp_load  = (state_ff == ST_FINISH) && slot_free;

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      end_in    = end_ff;
      acc_in    = acc_ff;
      neuron_in = neuron_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_if.payload.command == CMD_COMPUTE) && neuron_ok) begin
               state_in  = ST_RANGE;
               neuron_in = req_if.payload.index[9:0];
            end
         end
         ST_RANGE: begin
            acc_in   = ACC_W'($signed(bias_rd_data)) <<< 12;
            ptr_in   = PTR_W'(range_rd_data[14:0]);
            end_in   = range_end_clamped;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (issue) begin
               ptr_in = ptr_ff + PTR_W'(1);
            end
            if (s3_valid_ff) begin
               acc_in = acc_ff + ACC_W'(prod_ff);
            end
            if (!issue && !s1_valid_ff && !s2_valid_ff && !s3_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      end_ff       <= end_in;
      acc_ff       <= acc_in;
      neuron_ff    <= neuron_in;
      s2_weight_ff <= $signed(conn_rd_data[15:0]);
      s2_ok_ff     <= src_wide < 32'(INPUT_COUNT);
      prod_ff      <= s2_weight_ff * x_sel;
      if (rsp_load) begin
         rsp_data_ff.neuron         <= neuron_ff;
         rsp_data_ff.pre_activation <= pre_sat;
         rsp_data_ff.activation     <= act;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (!s1_valid_ff && !s2_valid_ff && !s3_valid_ff))
      else $error("finish reached with products still in flight");

   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> $past(s2_valid_ff))
      else $error("accumulate beat without a product stage before it");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised outside finish");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      (input_wr_en || bias_wr_en || conn_wr_en || range_wr_en) |-> !s1_valid_ff)
      else $error("store write while a walk is in flight");

endmodule

>>> tb/tb.sv
// testbench for the sparse layer forward block: directed and random store and compute traffic
module tb;
   import slr_pkg::*;

   localparam int IN_N         = 1024;
   localparam int NEURON_N     = 1024;
   localparam int CONN_N       = 16384;
   localparam int SPAN_MAX     = 32767;
   localparam int INDEX_MAX    = 16383;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 64;
   localparam int RANDOM_BEATS = 400;

   // commands the block must ignore
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   logic clock;
   logic reset;

   slr_stream_if #(.payload_type(req_payload_type)) req_if ();
   slr_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   sparse_layer_forward_leaky_relu #(
      .INPUT_COUNT(IN_N),
      .NEURON_COUNT(NEURON_N),
      .CONNECTION_COUNT(CONN_N)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   // mirror of the layer stores, with a flag per entry once written
   logic signed [15:0] act_mem     [IN_N];
   logic signed [15:0] bias_mem    [NEURON_N];
   logic [9:0]         conn_source [CONN_N];
   logic signed [15:0] conn_weight [CONN_N];
   logic [14:0]        span_begin  [NEURON_N];
   logic [14:0]        span_end    [NEURON_N];
   bit                 act_set     [IN_N];
   bit                 bias_set    [NEURON_N];
   bit                 conn_set    [CONN_N];
   bit                 span_set    [NEURON_N];

   rsp_payload_type pending_neurons [$];
   int              built_neurons [$];
   int              error_count = 0;
   int              cycle_count = 0;
   int              useful_beats = 0;
   bit              no_idle = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [15:0] rand_q();
      case ($urandom_range(0, 5))
         0, 1, 2: return 16'($urandom);
         3:       return 16'($urandom_range(0, 4095) - 2048);
         4: begin
            case ($urandom_range(0, 4))
               0:       return Q_MAX;
               1:       return Q_MIN;
               2:       return 16'sd1;
               3:       return -16'sd1;
               default: return 16'sd0;
            endcase
         end
         default: return 16'($urandom_range(0, 255) - 128);
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // bias plus weighted inputs, rounded half up to q4.12, saturated, then leaky relu
   function automatic rsp_payload_type forward_neuron(input int n);
      longint          sum;
      longint          rounded;
      int              stop;
      logic signed [15:0] pre;
      rsp_payload_type res;
      sum = longint'(bias_mem[n]) * 4096;
      stop = (span_end[n] > CONN_N) ? CONN_N : span_end[n];
      for (int i = span_begin[n]; i < stop; i++)
         sum += longint'(conn_weight[i]) *
                ((conn_source[i] < IN_N) ? longint'(act_mem[conn_source[i]]) : 64'sd0);
      rounded = (sum + 2048) >>> 12;
      if (rounded > 32767) rounded = 32767;
      if (rounded < -32768) rounded = -32768;
      pre = rounded[15:0];
      res.neuron = n[9:0];
      res.pre_activation = pre;
      res.activation = (pre > 0) ? pre : (pre >>> 1);
      return res;
   endfunction

   // update the mirror for one accepted beat; tells whether the beat had any effect
   function automatic bit apply_to_layer(input req_payload_type p);
      case (p.command)
         CMD_INPUT: if (p.index < IN_N) begin
            act_mem[p.index[9:0]] = p.value;
            act_set[p.index[9:0]] = 1;
            return 1;
         end
         CMD_BIAS: if (p.index < NEURON_N) begin
            bias_mem[p.index[9:0]] = p.value;
            bias_set[p.index[9:0]] = 1;
            return 1;
         end
         CMD_CONN: if (p.index < CONN_N) begin
            conn_source[p.index] = p.source;
            conn_weight[p.index] = p.value;
            conn_set[p.index] = 1;
            return 1;
         end
         CMD_RANGE: if (p.index < NEURON_N) begin
            span_begin[p.index[9:0]] = p.range_begin;
            span_end[p.index[9:0]] = p.range_end;
            span_set[p.index[9:0]] = 1;
            return 1;
         end
         CMD_COMPUTE: if (p.index < NEURON_N) begin
            pending_neurons = {pending_neurons, forward_neuron(p.index)};
            return 1;
         end
         default: ;
      endcase
      return 0;
   endfunction

   // a neuron may only be computed once every store entry it reads has been written
   function automatic bit neuron_computable(input int n);
      int stop;
      if (!bias_set[n] || !span_set[n]) return 0;
      stop = (span_end[n] > CONN_N) ? CONN_N : span_end[n];
      for (int i = span_begin[n]; i < stop; i++)
         if (!conn_set[i] || (conn_source[i] < IN_N && !act_set[conn_source[i]])) return 0;
      return 1;
   endfunction

   task automatic send_item(input req_payload_type p);
      int gap;
      gap = gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_if.payload = p;
      req_if.valid = 1;
      do @(posedge clock); while (!req_if.ready);
      if (apply_to_layer(p)) useful_beats++;
   endtask

   task automatic send_fields(input logic [2:0] cmd, input int idx, input int src,
                              input int val, input int rb, input int re);
      req_payload_type p;
      p.command = cmd;
      p.index = idx[13:0];
      p.source = src[9:0];
      p.value = val[15:0];
      p.range_begin = rb[14:0];
      p.range_end = re[14:0];
      send_item(p);
   endtask

   task automatic write_input(input int idx, input int val);
      send_fields(CMD_INPUT, idx, $urandom, val, $urandom, $urandom);
   endtask

   task automatic write_bias(input int idx, input int val);
      send_fields(CMD_BIAS, idx, $urandom, val, $urandom, $urandom);
   endtask

   task automatic write_conn(input int idx, input int src, input int val);
      send_fields(CMD_CONN, idx, src, val, $urandom, $urandom);
   endtask

   task automatic write_span(input int idx, input int rb, input int re);
      send_fields(CMD_RANGE, idx, $urandom, $urandom, rb, re);
   endtask

   task automatic compute_neuron(input int n);
      if (n >= NEURON_N || neuron_computable(n))
         send_fields(CMD_COMPUTE, n, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic test_saturation_and_rounding();
      write_input(0, Q_MIN);
      write_input(IN_N - 1, Q_MAX);
      write_input(1, 2048);
      write_conn(0, 0, Q_MIN);
      write_conn(CONN_N - 4, 0, Q_MAX);
      write_conn(CONN_N - 3, IN_N - 1, Q_MIN);
      write_conn(CONN_N - 2, 1, 1);
      write_conn(CONN_N - 1, 1, -1);
      // negative saturation, with a span end far past the connection store
      write_bias(0, Q_MAX);
      write_span(0, CONN_N - 4, SPAN_MAX);
      compute_neuron(0);
      // positive saturation from the most negative bias
      write_bias(NEURON_N - 1, Q_MIN);
      write_span(NEURON_N - 1, 0, 1);
      compute_neuron(NEURON_N - 1);
      // exact half of the last bit: plus rounds up, minus rounds to zero
      write_bias(1, 0);
      write_span(1, CONN_N - 2, CONN_N - 1);
      compute_neuron(1);
      write_bias(2, 0);
      write_span(2, CONN_N - 1, CONN_N);
      compute_neuron(2);
   endtask

   task automatic test_ignored_items();
      // out of range writes must not alias onto low entries
      write_input(IN_N, 16'sh1234);
      write_bias(NEURON_N + 1, Q_MAX);
      write_span(NEURON_N + NEURON_N - 1, 0, 0);
      send_fields(CMD_SPARE_LO, 1, 1, Q_MAX, 0, 0);
      send_fields(CMD_SPARE_HI, 1, 1, Q_MIN, 0, 0);
      // reversed span leaves the bias alone
      write_bias(3, -5);
      write_span(3, CONN_N - 1, CONN_N - 4);
      compute_neuron(3);
      compute_neuron(NEURON_N);
      compute_neuron(INDEX_MAX);
      compute_neuron(1);
      compute_neuron(NEURON_N - 1);
      compute_neuron(0);
   endtask

   task automatic test_random_traffic();
      int start;
      int pick;
      int n;
      int fan;
      int first;
      int last;
      int src;
      int stop;
      start = useful_beats;
      while (useful_beats - start < RANDOM_BEATS) begin
         if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            // well formed neuron: inputs, connections, often a new bias, span, then compute
            n = $urandom_range(0, NEURON_N - 1);
            pick = $urandom_range(0, 99);
            if (pick < 70) fan = $urandom_range(0, 6);
            else if (pick < 95) fan = $urandom_range(7, 24);
            else fan = $urandom_range(25, 48);
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               first = $urandom_range(0, SPAN_MAX);
               last = $urandom_range(0, first);
               fan = 0;
            end else if (pick < 25) begin
               first = CONN_N - fan;
               last = $urandom_range(CONN_N, SPAN_MAX);
            end else begin
               first = $urandom_range(0, CONN_N - fan);
               last = first + fan;
            end
            for (int i = 0; i < fan; i++) begin
               src = $urandom_range(0, IN_N - 1);
               if (!act_set[src] || $urandom_range(0, 3) == 0) write_input(src, rand_q());
               write_conn(first + i, src, rand_q());
            end
            if (!bias_set[n] || $urandom_range(0, 3) != 0) write_bias(n, rand_q());
            write_span(n, first, last);
            compute_neuron(n);
            built_neurons = {built_neurons, n};
         end else if (pick < 70) begin
            // recompute an earlier neuron, often after one of its inputs moved
            if (built_neurons.size() != 0) begin
               n = built_neurons[$urandom_range(0, built_neurons.size() - 1)];
               if (neuron_computable(n)) begin
                  stop = (span_end[n] > CONN_N) ? CONN_N : span_end[n];
                  if (span_begin[n] < stop && $urandom_range(0, 1) == 1)
                     write_input(conn_source[$urandom_range(span_begin[n], stop - 1)], rand_q());
                  compute_neuron(n);
               end
            end
         end else if (pick < 85) begin
            case ($urandom_range(0, 3))
               0: write_input($urandom_range(0, IN_N - 1), rand_q());
               1: write_bias($urandom_range(0, NEURON_N - 1), rand_q());
               2: write_conn($urandom_range(0, CONN_N - 1), $urandom_range(0, IN_N - 1),
                             rand_q());
               default: write_span($urandom_range(0, NEURON_N - 1),
                                   $urandom_range(0, SPAN_MAX), $urandom_range(0, SPAN_MAX));
            endcase
         end else begin
            // noise the block must drop
            case ($urandom_range(0, 4))
               0: write_input($urandom_range(IN_N, INDEX_MAX), rand_q());
               1: write_bias($urandom_range(NEURON_N, INDEX_MAX), rand_q());
               2: write_span($urandom_range(NEURON_N, INDEX_MAX), $urandom, $urandom);
               3: compute_neuron($urandom_range(NEURON_N, INDEX_MAX));
               default: send_fields(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                                    $urandom, $urandom, $urandom, $urandom, $urandom);
            endcase
         end
      end
      no_idle = 0;
   endtask

   // result side: random back-pressure
   initial begin
      int hold;
      hold = 0;
      rsp_if.ready = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_if.ready = 0;
            hold--;
         end else begin
            rsp_if.ready = 1;
            hold = gap_len();
         end
      end
   end

   always @(posedge clock) begin : take_result
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_neurons.size() == 0) begin
            report_mismatch($sformatf("result for neuron %0d with none expected",
                                      rsp_if.payload.neuron));
         end else begin
            want = pending_neurons.pop_front();
            if (rsp_if.payload.neuron !== want.neuron)
               report_mismatch($sformatf("neuron %0d, expected %0d",
                                         rsp_if.payload.neuron, want.neuron));
            if (rsp_if.payload.pre_activation !== want.pre_activation)
               report_mismatch($sformatf("neuron %0d pre_activation %0d, expected %0d",
                                         want.neuron, rsp_if.payload.pre_activation,
                                         want.pre_activation));
            if (rsp_if.payload.activation !== want.activation)
               report_mismatch($sformatf("neuron %0d activation %0d, expected %0d",
                                         want.neuron, rsp_if.payload.activation,
                                         want.activation));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      reset = 1;
      req_if.valid = 0;
      req_if.payload = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_saturation_and_rounding();
      test_ignored_items();
      test_random_traffic();
      @(negedge clock);
      req_if.valid = 0;
      while (pending_neurons.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule

>>> sparse_layer_forward_leaky_relu.f
sv/slr_pkg.sv
sv/slr_stream_if.sv
sv/slr_ram.sv
sv/sparse_layer_forward_leaky_relu.sv
tb/tb.sv
